// ===== rtl/dep_pkg.sv =====
// shared types, constants and helper functions for the determinant excitation phase block
// no dependencies; imported by dep_excite_core and determinant_excitation_phase
`default_nettype none

package dep_pkg;

    localparam int OCC_W = 64;
    localparam int IDX_W = 6;

    typedef enum logic [1:0] {
        KIND_SINGLE      = 2'd0,
        KIND_SAME_DOUBLE = 2'd1,
        KIND_OPP_DOUBLE  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [OCC_W-1:0]   alpha_occupancy;
        logic [OCC_W-1:0]   beta_occupancy;
        logic               spin_select;
        logic [IDX_W-1:0]   hole_first;
        logic [IDX_W-1:0]   hole_second;
        logic [IDX_W-1:0]   particle_first;
        logic [IDX_W-1:0]   particle_second;
    } t_request;

    typedef struct packed {
        logic [OCC_W-1:0]   alpha_result;
        logic [OCC_W-1:0]   beta_result;
        logic               applied;
        logic               phase_negative;
    } t_result;

    // single bit at orbital n
    function automatic logic [OCC_W-1:0] orb_bit(input logic [IDX_W-1:0] n);
        orb_bit = {{(OCC_W-1){1'b0}}, 1'b1} << n;
    endfunction

    // bits strictly between a and b, in either order
    function automatic logic [OCC_W-1:0] between_mask(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b
    );
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
        logic [OCC_W-1:0] below_hi;
        logic [OCC_W-1:0] above_lo;
        lo       = (a < b) ? a : b;
        hi       = (a < b) ? b : a;
        below_hi = orb_bit(hi) - {{(OCC_W-1){1'b0}}, 1'b1};
        // shifting a two past the top bit gives zero, so lo at the top leaves nothing above
        above_lo = ~(({{(OCC_W-2){1'b0}}, 2'b10} << lo) - {{(OCC_W-1){1'b0}}, 1'b1});
        between_mask = below_hi & above_lo;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dep_excite_core.sv =====
// combinational excitation check, occupancy update and fermion sign for one request
// depends on dep_pkg
`default_nettype none

module dep_excite_core #(
    parameter int ORBITALS = 64
) (
    input  dep_pkg::t_request i_req,
    output dep_pkg::t_result  o_res
);
    import dep_pkg::*;

    localparam logic [OCC_W-1:0] ORB_MASK  = (ORBITALS >= OCC_W) ? {OCC_W{1'b1}} :
        ((({{(OCC_W-1){1'b0}}, 1'b1}) << ORBITALS) - {{(OCC_W-1){1'b0}}, 1'b1});
    localparam logic [IDX_W:0]   IDX_LIMIT = (IDX_W+1)'(ORBITALS);

    logic [OCC_W-1:0] occ_a;
    logic [OCC_W-1:0] occ_b;
    logic [OCC_W-1:0] occ_sel;
    logic [OCC_W-1:0] occ_one;
    logic [OCC_W-1:0] occ_two;
    logic [OCC_W-1:0] bit_h1;
    logic [OCC_W-1:0] bit_h2;
    logic [OCC_W-1:0] bit_p1;
    logic [OCC_W-1:0] bit_p2;
    logic             sign_one;
    logic             sign_two;
    logic             range_one;
    logic             range_all;
    logic             ok;
    logic             neg;
    logic [OCC_W-1:0] new_single;
    logic [OCC_W-1:0] new_double;
    logic [OCC_W-1:0] new_two;
    logic [OCC_W-1:0] res_a;
    logic [OCC_W-1:0] res_b;

    assign occ_a   = i_req.alpha_occupancy & ORB_MASK;
    assign occ_b   = i_req.beta_occupancy & ORB_MASK;
    assign occ_sel = i_req.spin_select ? occ_b : occ_a;
    // opposite-spin doubles split the pairs across the channels
    assign occ_one = (i_req.kind == KIND_OPP_DOUBLE) ? occ_a : occ_sel;
    assign occ_two = (i_req.kind == KIND_OPP_DOUBLE) ? occ_b : occ_sel;

    assign bit_h1 = orb_bit(i_req.hole_first);
    assign bit_h2 = orb_bit(i_req.hole_second);
    assign bit_p1 = orb_bit(i_req.particle_first);
    assign bit_p2 = orb_bit(i_req.particle_second);

    assign sign_one = ^(occ_one & between_mask(i_req.hole_first, i_req.particle_first));
    assign sign_two = ^(occ_two & between_mask(i_req.hole_second, i_req.particle_second));

    assign range_one = ({1'b0, i_req.hole_first} < IDX_LIMIT) &&
                       ({1'b0, i_req.particle_first} < IDX_LIMIT);
    assign range_all = range_one &&
                       ({1'b0, i_req.hole_second} < IDX_LIMIT) &&
                       ({1'b0, i_req.particle_second} < IDX_LIMIT);

    assign new_single = (occ_one & ~bit_h1) | bit_p1;
    assign new_double = (occ_one & ~(bit_h1 | bit_h2)) | bit_p1 | bit_p2;
    assign new_two    = (occ_two & ~bit_h2) | bit_p2;

    always_comb begin
        ok    = 1'b0;
        neg   = 1'b0;
        res_a = occ_a;
        res_b = occ_b;
        case (i_req.kind)
            KIND_SINGLE: begin
                neg = sign_one;
                ok  = range_one && occ_one[i_req.hole_first] && !occ_one[i_req.particle_first];
                if (ok) begin
                    if (i_req.spin_select) begin
                        res_b = new_single;
                    end else begin
                        res_a = new_single;
                    end
                end
            end
            KIND_SAME_DOUBLE: begin
                neg = sign_one ^ sign_two ^ (i_req.hole_second < i_req.particle_first)
                    ^ (i_req.particle_second < i_req.hole_first);
                ok  = range_all &&
                      (i_req.hole_first != i_req.hole_second) &&
                      (i_req.particle_first != i_req.particle_second) &&
                      occ_one[i_req.hole_first] && occ_one[i_req.hole_second] &&
                      !occ_one[i_req.particle_first] && !occ_one[i_req.particle_second];
                if (ok) begin
                    if (i_req.spin_select) begin
                        res_b = new_double;
                    end else begin
                        res_a = new_double;
                    end
                end
            end
            KIND_OPP_DOUBLE: begin
                neg = sign_one ^ sign_two;
                ok  = range_all &&
                      occ_one[i_req.hole_first] && !occ_one[i_req.particle_first] &&
                      occ_two[i_req.hole_second] && !occ_two[i_req.particle_second];
                if (ok) begin
                    res_a = new_single;
                    res_b = new_two;
                end
            end
            default: begin
                ok  = 1'b0;
                neg = 1'b0;
            end
        endcase
    end

    assign o_res.alpha_result   = res_a & ORB_MASK;
    assign o_res.beta_result    = res_b & ORB_MASK;
    assign o_res.applied        = ok;
    assign o_res.phase_negative = neg;

endmodule

`default_nettype wire

// ===== rtl/determinant_excitation_phase.sv =====
// top level: slater determinant excitation with fermion sign, two register stages
// depends on dep_pkg and dep_excite_core
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  kind, alpha/beta occupancy, spin, four orbitals
//   result    out        o_valid / i_stall  alpha/beta result, applied, phase_negative
//
// one transaction per cycle sustained while the result side is not stalling
// stage one is the request register, stage two the result register; the excitation
// logic (bit tests, masks and two 64-bit parity trees) sits between them
// synchronous active-low reset empties both stages; payload registers are not reset
// a stalled result holds in stage two, and the request side stalls only when both
// stages are full and the result side is stalling
`default_nettype none

module determinant_excitation_phase #(
    parameter int ORBITALS = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request channel
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic [1:0]                  i_kind,
    input  wire logic [dep_pkg::OCC_W-1:0]   i_alpha_occupancy,
    input  wire logic [dep_pkg::OCC_W-1:0]   i_beta_occupancy,
    input  wire logic                        i_spin_select,
    input  wire logic [dep_pkg::IDX_W-1:0]   i_hole_first,
    input  wire logic [dep_pkg::IDX_W-1:0]   i_hole_second,
    input  wire logic [dep_pkg::IDX_W-1:0]   i_particle_first,
    input  wire logic [dep_pkg::IDX_W-1:0]   i_particle_second,
    // result channel
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic [dep_pkg::OCC_W-1:0]        o_alpha_result,
    output logic [dep_pkg::OCC_W-1:0]        o_beta_result,
    output logic                             o_applied,
    output logic                             o_phase_negative
);
    import dep_pkg::*;

    // stage one: registered request
    logic     r_s1_valid;
    logic     n_s1_valid;
    t_request r_req;
    // stage two: registered result
    logic     r_out_valid;
    logic     n_out_valid;
    t_result  r_res;
    t_result  core_res;

    logic in_accept;
    logic out_hold;
    logic s1_advance;

    // result stage is blocked only while it holds a transaction the sink is stalling
    assign out_hold   = r_out_valid && i_stall;
    assign s1_advance = r_s1_valid && !out_hold;
    assign o_stall    = r_s1_valid && out_hold;
    assign in_accept  = i_valid && !o_stall;

    always_comb begin
        n_s1_valid  = in_accept || (r_s1_valid && out_hold);
        n_out_valid = s1_advance || out_hold;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req.kind            <= t_kind'(i_kind);
            r_req.alpha_occupancy <= i_alpha_occupancy;
            r_req.beta_occupancy  <= i_beta_occupancy;
            r_req.spin_select     <= i_spin_select;
            r_req.hole_first      <= i_hole_first;
            r_req.hole_second     <= i_hole_second;
            r_req.particle_first  <= i_particle_first;
            r_req.particle_second <= i_particle_second;
        end
    end

    dep_excite_core #(
        .ORBITALS (ORBITALS)
    ) u_core (
        .i_req (r_req),
        .o_res (core_res)
    );

    // result capture, held while the sink stalls
    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_res <= core_res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_alpha_result   = r_res.alpha_result;
    assign o_beta_result    = r_res.beta_result;
    assign o_applied        = r_res.applied;
    assign o_phase_negative = r_res.phase_negative;

endmodule

`default_nettype wire

// ===== rtl/dep_checker.sv =====
// port-level checks for determinant_excitation_phase, attached by bind
// no package dependencies; sees the top level's ports only
`default_nettype none

module dep_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [63:0] o_alpha_result,
    input wire logic [63:0] o_beta_result,
    input wire logic        o_applied,
    input wire logic        o_phase_negative
);

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result valid right after reset");

    // a stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_alpha_result) &&
        $stable(o_beta_result) && $stable(o_applied) && $stable(o_phase_negative))
        else $error("stalled result changed");

    // request side stalls only when a result is held back
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stall without a held result");

    // a fresh result follows an accepted transaction, registered as a request and then again as a result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(i_valid && !o_stall, 2))
        else $error("result appeared without a matching request");

endmodule

bind determinant_excitation_phase dep_checker u_dep_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_alpha_result   (o_alpha_result),
    .o_beta_result    (o_beta_result),
    .o_applied        (o_applied),
    .o_phase_negative (o_phase_negative)
);

`default_nettype wire

// ===== test/tb_top.sv =====
// testbench for determinant_excitation_phase: directed and random excitation requests
// checked field by field against an in-bench predictor of the resulting occupancy and sign
// depends on dep_pkg and the determinant_excitation_phase rtl only

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dep_pkg::*;

    // orbital count the block is built with; occupancy bits above it are dropped
    localparam int ORBITALS = 64;
    localparam logic [OCC_W-1:0] ORB_MASK =
        (ORBITALS >= OCC_W) ? {OCC_W{1'b1}} : ((64'd1 << ORBITALS) - 64'd1);

    // the kind code that the package leaves unnamed; the block treats it as a no-op
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RANDOM_COUNT  = 1700;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_EVERY   = 500;
    localparam int DRAIN_OFFSET  = 250;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #2 i_clk = ~i_clk;

    // request side, the block's inputs all driven from time zero
    logic             i_valid           = 1'b0;
    logic             o_stall;
    logic [1:0]       i_kind            = '0;
    logic [OCC_W-1:0] i_alpha_occupancy = '0;
    logic [OCC_W-1:0] i_beta_occupancy  = '0;
    logic             i_spin_select     = 1'b0;
    logic [IDX_W-1:0] i_hole_first      = '0;
    logic [IDX_W-1:0] i_hole_second     = '0;
    logic [IDX_W-1:0] i_particle_first  = '0;
    logic [IDX_W-1:0] i_particle_second = '0;

    // result side
    logic             o_valid;
    logic             i_stall;
    logic [OCC_W-1:0] o_alpha_result;
    logic [OCC_W-1:0] o_beta_result;
    logic             o_applied;
    logic             o_phase_negative;

    determinant_excitation_phase #(
        .ORBITALS(ORBITALS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_alpha_occupancy(i_alpha_occupancy),
        .i_beta_occupancy (i_beta_occupancy),
        .i_spin_select    (i_spin_select),
        .i_hole_first     (i_hole_first),
        .i_hole_second    (i_hole_second),
        .i_particle_first (i_particle_first),
        .i_particle_second(i_particle_second),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_alpha_result   (o_alpha_result),
        .o_beta_result    (o_beta_result),
        .o_applied        (o_applied),
        .o_phase_negative (o_phase_negative)
    );

    // requests waiting to be offered, and excitation results still owed by the block
    t_request request_q[$];
    t_result  excitation_q[$];

    int error_count = 0;
    int accepted_n  = 0;   // request transactions taken by the block
    int received_n  = 0;   // result transactions taken from the block
    int total_n     = 0;   // request transactions queued for the whole run

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // parity of the occupied orbitals strictly between a and b
    function automatic bit span_parity(logic [OCC_W-1:0] occ, logic [IDX_W-1:0] a,
                                       logic [IDX_W-1:0] b);
        int lo;
        int hi;
        bit acc;
        lo  = int'((a < b) ? a : b);
        hi  = int'((a < b) ? b : a);
        acc = 1'b0;
        for (int i = lo + 1; i < hi; i++)
            acc ^= occ[i];
        return acc;
    endfunction

    function automatic t_result excite_predict(t_request rq);
        t_result          res;
        logic [OCC_W-1:0] alpha;
        logic [OCC_W-1:0] beta;
        logic [OCC_W-1:0] occ;
        logic [OCC_W-1:0] h1_bit;
        logic [OCC_W-1:0] h2_bit;
        logic [OCC_W-1:0] p1_bit;
        logic [OCC_W-1:0] p2_bit;
        bit               first_fits;
        bit               all_fit;
        bit               ok;
        bit               neg;
        alpha      = rq.alpha_occupancy & ORB_MASK;
        beta       = rq.beta_occupancy & ORB_MASK;
        occ        = rq.spin_select ? beta : alpha;
        h1_bit     = 64'd1 << rq.hole_first;
        h2_bit     = 64'd1 << rq.hole_second;
        p1_bit     = 64'd1 << rq.particle_first;
        p2_bit     = 64'd1 << rq.particle_second;
        first_fits = (int'(rq.hole_first) < ORBITALS) && (int'(rq.particle_first) < ORBITALS);
        all_fit    = first_fits && (int'(rq.hole_second) < ORBITALS) &&
                     (int'(rq.particle_second) < ORBITALS);
        ok         = 1'b0;
        neg        = 1'b0;
        case (rq.kind)
            KIND_SINGLE: begin
                neg = span_parity(occ, rq.hole_first, rq.particle_first);
                ok  = first_fits && ((occ & h1_bit) != 0) && ((occ & p1_bit) == 0);
                if (ok) begin
                    occ = (occ & ~h1_bit) | p1_bit;
                    if (rq.spin_select) beta = occ;
                    else alpha = occ;
                end
            end
            KIND_SAME_DOUBLE: begin
                // both singles on the untouched occupancy, plus the two crossing flips
                neg = span_parity(occ, rq.hole_first, rq.particle_first) ^
                      span_parity(occ, rq.hole_second, rq.particle_second);
                if (rq.hole_second < rq.particle_first) neg = ~neg;
                if (rq.particle_second < rq.hole_first) neg = ~neg;
                ok = all_fit && (rq.hole_first != rq.hole_second) &&
                     (rq.particle_first != rq.particle_second) &&
                     ((occ & h1_bit) != 0) && ((occ & h2_bit) != 0) &&
                     ((occ & p1_bit) == 0) && ((occ & p2_bit) == 0);
                if (ok) begin
                    occ = (occ & ~(h1_bit | h2_bit)) | p1_bit | p2_bit;
                    if (rq.spin_select) beta = occ;
                    else alpha = occ;
                end
            end
            KIND_OPP_DOUBLE: begin
                neg = span_parity(alpha, rq.hole_first, rq.particle_first) ^
                      span_parity(beta, rq.hole_second, rq.particle_second);
                ok  = all_fit && ((alpha & h1_bit) != 0) && ((alpha & p1_bit) == 0) &&
                      ((beta & h2_bit) != 0) && ((beta & p2_bit) == 0);
                if (ok) begin
                    alpha = (alpha & ~h1_bit) | p1_bit;
                    beta  = (beta & ~h2_bit) | p2_bit;
                end
            end
            default: ;  // unused kind: nothing applied, positive sign
        endcase
        res.alpha_result   = alpha & ORB_MASK;
        res.beta_result    = beta & ORB_MASK;
        res.applied        = ok;
        res.phase_negative = neg;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    task automatic add_request(input logic [1:0] k, input logic [OCC_W-1:0] a,
                               input logic [OCC_W-1:0] b, input logic s,
                               input logic [IDX_W-1:0] h1, input logic [IDX_W-1:0] h2,
                               input logic [IDX_W-1:0] p1, input logic [IDX_W-1:0] p2);
        t_request rq;
        rq.kind            = t_kind'(k);
        rq.alpha_occupancy = a;
        rq.beta_occupancy  = b;
        rq.spin_select     = s;
        rq.hole_first      = h1;
        rq.hole_second     = h2;
        rq.particle_first  = p1;
        rq.particle_second = p2;
        request_q.insert(request_q.size(), rq);
    endtask

    // mix of dense, sparse, uniform and degenerate bitstrings
    function automatic logic [OCC_W-1:0] random_occupancy();
        logic [OCC_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1:    v = v & {$urandom, $urandom} & {$urandom, $urandom};
            2, 3:    v = v | {$urandom, $urandom} | {$urandom, $urandom};
            4:       v = $urandom_range(0, 1) ? '1 : '0;
            default: ;
        endcase
        return v;
    endfunction

    // mostly well-formed excitations with random content, the rest noise
    function automatic t_request draw_request();
        t_request         rq;
        logic [1:0]       k;
        logic [OCC_W-1:0] occ_a;
        logic [OCC_W-1:0] occ_b;
        logic [OCC_W-1:0] occ;
        occ_a              = random_occupancy();
        occ_b              = random_occupancy();
        k                  = ($urandom_range(0, 19) == 0) ? KIND_UNUSED
                                                           : 2'($urandom_range(0, 2));
        rq.kind            = t_kind'(k);
        rq.spin_select     = 1'($urandom_range(0, 1));
        rq.hole_first      = 6'($urandom_range(0, 63));
        rq.hole_second     = 6'($urandom_range(0, 63));
        rq.particle_first  = 6'($urandom_range(0, 63));
        rq.particle_second = 6'($urandom_range(0, 63));
        if ($urandom_range(0, 3) != 0) begin
            if (k == KIND_SAME_DOUBLE) begin
                // four distinct orbitals in one channel
                while (rq.hole_second == rq.hole_first)
                    rq.hole_second = 6'($urandom_range(0, 63));
                while (rq.particle_first == rq.hole_first ||
                       rq.particle_first == rq.hole_second)
                    rq.particle_first = 6'($urandom_range(0, 63));
                while (rq.particle_second == rq.hole_first ||
                       rq.particle_second == rq.hole_second ||
                       rq.particle_second == rq.particle_first)
                    rq.particle_second = 6'($urandom_range(0, 63));
            end else begin
                while (rq.particle_first == rq.hole_first)
                    rq.particle_first = 6'($urandom_range(0, 63));
                while (rq.particle_second == rq.hole_second)
                    rq.particle_second = 6'($urandom_range(0, 63));
            end
            // make holes occupied and particles empty
            occ = rq.spin_select ? occ_b : occ_a;
            case (k)
                KIND_SINGLE: begin
                    occ = (occ | (64'd1 << rq.hole_first)) & ~(64'd1 << rq.particle_first);
                    if (rq.spin_select) occ_b = occ;
                    else occ_a = occ;
                end
                KIND_SAME_DOUBLE: begin
                    occ = occ | (64'd1 << rq.hole_first) | (64'd1 << rq.hole_second);
                    occ = occ & ~((64'd1 << rq.particle_first) |
                                  (64'd1 << rq.particle_second));
                    if (rq.spin_select) occ_b = occ;
                    else occ_a = occ;
                end
                KIND_OPP_DOUBLE: begin
                    occ_a = (occ_a | (64'd1 << rq.hole_first)) &
                            ~(64'd1 << rq.particle_first);
                    occ_b = (occ_b | (64'd1 << rq.hole_second)) &
                            ~(64'd1 << rq.particle_second);
                end
                default: ;
            endcase
        end else if ($urandom_range(0, 2) == 0) begin
            // broken double: coincident holes or coincident particles
            if ($urandom_range(0, 1)) rq.hole_second = rq.hole_first;
            else rq.particle_second = rq.particle_first;
        end
        rq.alpha_occupancy = occ_a;
        rq.beta_occupancy  = occ_b;
        return rq;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued requests with random gaps, holds payload while stalled
    // ------------------------------------------------------------------

    t_request offered;
    int       tx_gap   = 0;
    bit       tx_burst = 1'b0;

    always @(posedge i_clk) begin
        t_request nxt;
        bit       drain_hold;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap  <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                excitation_q.insert(excitation_q.size(), excite_predict(offered));
                accepted_n <= accepted_n + 1;
            end
            // now and then the sender waits for every owed result before going on
            drain_hold = ((accepted_n % DRAIN_EVERY) == DRAIN_OFFSET) &&
                         (excitation_q.size() != 0);
            if (!(i_valid && o_stall)) begin
                if (tx_gap != 0) begin
                    tx_gap  <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (request_q.size() == 0 || drain_hold) begin
                    i_valid <= 1'b0;
                end else begin
                    nxt               = request_q.pop_front();
                    offered           <= nxt;
                    i_kind            <= nxt.kind;
                    i_alpha_occupancy <= nxt.alpha_occupancy;
                    i_beta_occupancy  <= nxt.beta_occupancy;
                    i_spin_select     <= nxt.spin_select;
                    i_hole_first      <= nxt.hole_first;
                    i_hole_second     <= nxt.hole_second;
                    i_particle_first  <= nxt.particle_first;
                    i_particle_second <= nxt.particle_second;
                    i_valid           <= 1'b1;
                    // gap before the next request; burst stretches have none
                    tx_gap            <= tx_burst ? 0 : $urandom_range(0, 5);
                    if ((request_q.size() % 40) == 0)
                        tx_burst <= ($urandom_range(0, 3) == 0);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall: short random waits per result plus rare long hold-offs
    // ------------------------------------------------------------------

    bit rx_wait     = 1'b0;
    int rx_left     = 0;
    bit rx_burst    = 1'b0;
    int hold_left   = 0;
    int next_hold_n = 700;

    assign i_stall = rx_wait || (hold_left != 0);

    // long hold-off while the sender keeps offering, so both stages fill and o_stall rises
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (accepted_n >= next_hold_n && hold_left == 0) begin
            hold_left   <= HOLD_CYCLES;
            next_hold_n <= next_hold_n + 600;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic report_mismatch(input string what, input logic [OCC_W-1:0] got,
                                   input logic [OCC_W-1:0] want);
        $display("mismatch at result %0d: %s got %h want %h", received_n, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // monitor: every result transaction against the oldest owed result
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_result want;
        int      wait_n;
        if (!i_rst_n) begin
            rx_wait <= 1'b0;
            rx_left <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (excitation_q.size() == 0) begin
                    report_mismatch("unexpected result, alpha", o_alpha_result, '0);
                end else begin
                    want = excitation_q.pop_front();
                    if (o_alpha_result !== want.alpha_result)
                        report_mismatch("alpha_result", o_alpha_result, want.alpha_result);
                    if (o_beta_result !== want.beta_result)
                        report_mismatch("beta_result", o_beta_result, want.beta_result);
                    if (o_applied !== want.applied)
                        report_mismatch("applied", 64'(o_applied), 64'(want.applied));
                    if (o_phase_negative !== want.phase_negative)
                        report_mismatch("phase_negative", 64'(o_phase_negative),
                                        64'(want.phase_negative));
                end
                received_n <= received_n + 1;
                if ((received_n % 40) == 0)
                    rx_burst <= ($urandom_range(0, 3) == 0);
                // stall drawn for the next result
                wait_n  = rx_burst ? 0 : $urandom_range(0, 5);
                rx_left <= wait_n;
                rx_wait <= (wait_n != 0);
            end else if (rx_left > 1) begin
                rx_left <= rx_left - 1;
            end else begin
                rx_left <= 0;
                rx_wait <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------

    int cycle_n = 0;

    always @(posedge i_clk) begin
        cycle_n <= cycle_n + 1;
        if (cycle_n == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_n, excitation_q.size());
            $display("** determinant_excitation_phase: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, directed cases, random traffic, drain
    // ------------------------------------------------------------------

    initial begin
        // directed: singles at the orbital extremes, both channels
        add_request(KIND_SINGLE, 64'h7FFF_FFFF_FFFF_FFFF, 64'h0, 1'b0, 6'd0, 6'd0, 6'd63, 6'd0);
        add_request(KIND_SINGLE, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 6'd63, 6'd0, 6'd0, 6'd0);
        // adjacent orbitals, nothing in between
        add_request(KIND_SINGLE, 64'h20, 64'h0, 1'b0, 6'd5, 6'd0, 6'd6, 6'd0);
        // hole equals particle, never applies
        add_request(KIND_SINGLE, 64'h10, 64'h0, 1'b0, 6'd4, 6'd0, 6'd4, 6'd0);
        // empty hole, full particle, empty channel
        add_request(KIND_SINGLE, 64'h0, 64'hFFFF, 1'b0, 6'd3, 6'd0, 6'd9, 6'd0);
        add_request(KIND_SINGLE, '1, '1, 1'b0, 6'd2, 6'd0, 6'd50, 6'd0);
        add_request(KIND_SINGLE, '1, 64'h0, 1'b1, 6'd0, 6'd0, 6'd63, 6'd0);
        // same-spin doubles: both crossing flips, one flip, extremes in beta
        add_request(KIND_SAME_DOUBLE, 64'h0000_0108_0200_8400, 64'h0, 1'b0,
                    6'd40, 6'd10, 6'd20, 6'd30);
        add_request(KIND_SAME_DOUBLE, 64'h0004_0000_0000_0020 | 64'h0000_0F00_0000_0F00, '1,
                    1'b0, 6'd50, 6'd5, 6'd10, 6'd60);
        add_request(KIND_SAME_DOUBLE, 64'h0, 64'h5555_5555_5555_5556, 1'b1,
                    6'd1, 6'd62, 6'd0, 6'd63);
        // coincident holes, coincident particles, one hole empty
        add_request(KIND_SAME_DOUBLE, 64'hFFFF_0000_FFFF_0000, 64'h0, 1'b0,
                    6'd20, 6'd20, 6'd5, 6'd40);
        add_request(KIND_SAME_DOUBLE, 64'h0000_0000_0003_0000, 64'h0, 1'b0,
                    6'd16, 6'd17, 6'd3, 6'd3);
        add_request(KIND_SAME_DOUBLE, 64'h0000_0000_0001_0000, 64'h0, 1'b0,
                    6'd16, 6'd17, 6'd3, 6'd4);
        // opposite-spin doubles: applied, beta hole empty, alpha particle full, all full
        add_request(KIND_OPP_DOUBLE, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0,
                    6'd1, 6'd63, 6'd60, 6'd0);
        add_request(KIND_OPP_DOUBLE, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1,
                    6'd1, 6'd0, 6'd60, 6'd63);
        add_request(KIND_OPP_DOUBLE, 64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0, 1'b0,
                    6'd1, 6'd63, 6'd2, 6'd0);
        add_request(KIND_OPP_DOUBLE, '1, '1, 1'b0, 6'd63, 6'd0, 6'd0, 6'd63);
        // unused kind passes occupancy through
        add_request(KIND_UNUSED, 64'hDEAD_BEEF_0123_4567, 64'h89AB_CDEF_FEDC_BA98, 1'b1,
                    6'd7, 6'd40, 6'd33, 6'd12);
        add_request(KIND_UNUSED, '1, '0, 1'b0, 6'd63, 6'd63, 6'd63, 6'd63);

        for (int i = 0; i < RANDOM_COUNT; i++)
            request_q.insert(request_q.size(), draw_request());
        total_n = request_q.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests taken, then every owed result back
        while (accepted_n != total_n || excitation_q.size() != 0)
            @(posedge i_clk);
        // run on a little longer to catch any stray result
        repeat (8) @(posedge i_clk);

        if (error_count == 0)
            $display("** determinant_excitation_phase: PASSED **");
        else
            $display("** determinant_excitation_phase: FAILED **");
        $finish;
    end

endmodule

// ===== determinant_excitation_phase.f =====
rtl/dep_pkg.sv
rtl/dep_excite_core.sv
rtl/determinant_excitation_phase.sv
rtl/dep_checker.sv
test/tb_top.sv
